FILE: rtl/ibm_pkg.sv
// Shared types, command codes and step tables for the I2C bit-level master.
`default_nettype none
package ibm_pkg;

	// Action codes carried by an input beat.
	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;
	localparam logic [2:0] ACT_SACK  = 3'd5;
	localparam logic [2:0] ACT_RACK  = 3'd6;
	localparam logic [2:0] ACT_PULSE = 3'd7;

	// The idle command shares the tick code.
	localparam logic [2:0] CMD_IDLE = 3'd0;

	// Reset value of the step length register.
	localparam logic [15:0] PHASE_RESET = 16'd20;

	// Bit position that write byte drives first.
	localparam int MSB_IDX = 7;

	// Classified item as it travels from the front to the back.
	typedef struct packed {
		logic       is_tick;
		logic [2:0] cmd;
		logic       load_shift;
		logic [7:0] load_val;
		logic       sda_in;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       rx_ack;
		logic       status;
	} result_t;

	// Number of pin steps in each command.
	function automatic logic [4:0] step_total(input logic [2:0] cmd);
		logic [4:0] n;
		case (cmd)
			ACT_START: n = 5'd4;
			ACT_STOP:  n = 5'd3;
			ACT_WRITE: n = 5'd24;
			ACT_READ:  n = 5'd25;
			ACT_SACK:  n = 5'd3;
			ACT_RACK:  n = 5'd4;
			ACT_PULSE: n = 5'd2;
			default:   n = 5'd1;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/ibm_if.sv
// Channel interfaces: command input, result output and configuration write.
`default_nettype none
interface ibm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] tx_byte;
	logic       ack_bit;
	logic       sda_in;
	modport source (output valid, action, tx_byte, ack_bit, sda_in, input ready);
	modport sink   (input valid, action, tx_byte, ack_bit, sda_in, output ready);
endinterface

interface ibm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       rx_ack;
	logic       status;
	modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte, rx_ack,
		status, input ready);
	modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte, rx_ack,
		status, output ready);
endinterface

interface ibm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ibm_front.sv
// Front end: accepts command beats and classifies them into queue items.
`default_nettype none
module ibm_front import ibm_pkg::*; (
	ibm_cmd_if.sink    cmd,
	input  wire logic  q_full,
	output logic       q_push,
	output item_t      q_item
);

	// Accept whenever the queue has room.
	assign cmd.ready = !q_full;
	assign q_push    = cmd.valid && !q_full;

	// Decode the action and pick the value that preloads the shift register.
	always_comb begin
		q_item.is_tick    = (cmd.action == ACT_TICK);
		q_item.cmd        = cmd.action;
		q_item.sda_in     = cmd.sda_in;
		q_item.load_shift = 1'b0;
		q_item.load_val   = 8'h00;
		case (cmd.action)
			ACT_WRITE: begin
				q_item.load_shift = 1'b1;
				q_item.load_val   = cmd.tx_byte;
			end
			ACT_READ: begin
				q_item.load_shift = 1'b1;
			end
			ACT_SACK: begin
				q_item.load_shift = 1'b1;
				q_item.load_val   = {7'b0, cmd.ack_bit};
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/ibm_queue.sv
// Two-entry queue that decouples the front end from the sequencer.
`default_nettype none
module ibm_queue import ibm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       not_empty,
	output item_t      pop_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_item  = mem_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ibm_back.sv
// Back end: pin-step sequencer state and the registered result stage.
`default_nettype none
module ibm_back import ibm_pkg::*; #(
	parameter int PRESCALE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] phase_ticks,
	input  wire logic        q_not_empty,
	input  wire item_t       q_item,
	output logic             q_pop,
	ibm_res_if.source        res
);

	// Sequencer state.
	logic        scl_q, sda_q;
	logic [2:0]  cmd_q;
	logic [4:0]  step_q;
	logic [1:0]  sub_q;
	logic [7:0]  shift_q;
	logic [7:0]  rxb_q;
	logic        rxa_q;
	logic [15:0] pc_q;

	logic        scl_n, sda_n;
	logic [2:0]  cmd_n;
	logic [4:0]  step_n;
	logic [1:0]  sub_n;
	logic [7:0]  shift_n;
	logic [7:0]  rxb_n;
	logic        rxa_n;
	logic [15:0] pc_n;
	logic        done_n, status_n;

	logic [15:0] len_mask;
	logic [15:0] len_raw;
	logic [15:0] step_len;
	logic [16:0] pc_inc;
	logic [4:0]  step_inc;
	logic [1:0]  sub_wrap;

	// Output stage.
	logic        out_valid_q;
	result_t     out_q;

	// Pop when the output stage is free or being drained.
	assign q_pop = q_not_empty && (!out_valid_q || res.ready);

	// Effective step length: mask to the prescaler width, zero counts as one.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			len_mask[i] = (i < PRESCALE_BITS);
		end
		len_raw  = phase_ticks & len_mask;
		step_len = (len_raw == 16'd0) ? 16'd1 : len_raw;
	end

	assign pc_inc   = {1'b0, pc_q} + 17'd1;
	assign step_inc = step_q + 5'd1;
	assign sub_wrap = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;

	// Next state for the item at the head of the queue.
	always_comb begin
		scl_n    = scl_q;
		sda_n    = sda_q;
		cmd_n    = cmd_q;
		step_n   = step_q;
		sub_n    = sub_q;
		shift_n  = shift_q;
		rxb_n    = rxb_q;
		rxa_n    = rxa_q;
		pc_n     = pc_q;
		done_n   = 1'b0;
		status_n = 1'b0;
		if (q_item.is_tick) begin
			if (cmd_q != CMD_IDLE) begin
				// The pin action or sample happens on the first tick of a step.
				if (pc_q == 16'd0) begin
					case (cmd_q)
						ACT_START: begin
							case (step_q)
								5'd0:    sda_n = 1'b1;
								5'd1:    scl_n = 1'b1;
								5'd2:    sda_n = 1'b0;
								default: scl_n = 1'b0;
							endcase
						end
						ACT_STOP: begin
							case (step_q)
								5'd0:    sda_n = 1'b0;
								5'd1:    scl_n = 1'b1;
								default: sda_n = 1'b1;
							endcase
						end
						ACT_WRITE: begin
							case (sub_q)
								2'd0: begin
									sda_n   = shift_q[MSB_IDX];
									shift_n = {shift_q[6:0], 1'b0};
								end
								2'd1:    scl_n = 1'b1;
								default: scl_n = 1'b0;
							endcase
						end
						ACT_READ: begin
							if (step_q == 5'd0) begin
								sda_n = 1'b1;
							end else begin
								case (sub_q)
									2'd0:    scl_n = 1'b1;
									2'd1:    shift_n = {shift_q[6:0], q_item.sda_in};
									default: scl_n = 1'b0;
								endcase
							end
						end
						ACT_SACK: begin
							case (step_q)
								5'd0:    sda_n = shift_q[0];
								5'd1:    scl_n = 1'b1;
								default: scl_n = 1'b0;
							endcase
						end
						ACT_RACK: begin
							case (step_q)
								5'd0:    sda_n = 1'b1;
								5'd1:    scl_n = 1'b1;
								5'd2:    rxa_n = q_item.sda_in;
								default: scl_n = 1'b0;
							endcase
						end
						ACT_PULSE: begin
							scl_n = (step_q == 5'd0);
						end
						default: begin
						end
					endcase
				end
				// Step timing and advance to the next step.
				if (pc_inc >= {1'b0, step_len}) begin
					pc_n = 16'd0;
					if (cmd_q == ACT_WRITE) begin
						sub_n = sub_wrap;
					end else if (cmd_q == ACT_READ && step_q != 5'd0) begin
						sub_n = sub_wrap;
					end
					if (step_inc >= step_total(cmd_q)) begin
						if (cmd_q == ACT_READ) begin
							rxb_n = shift_n;
						end
						cmd_n  = CMD_IDLE;
						step_n = 5'd0;
						done_n = 1'b1;
					end else begin
						step_n = step_inc;
					end
				end else begin
					pc_n = pc_inc[15:0];
				end
			end
		end else if (cmd_q != CMD_IDLE) begin
			// A command while busy is refused and changes nothing.
			status_n = 1'b1;
		end else begin
			cmd_n  = q_item.cmd;
			step_n = 5'd0;
			sub_n  = 2'd0;
			pc_n   = 16'd0;
			if (q_item.load_shift) begin
				shift_n = q_item.load_val;
			end
		end
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			cmd_q   <= CMD_IDLE;
			step_q  <= 5'd0;
			sub_q   <= 2'd0;
			shift_q <= 8'h00;
			rxb_q   <= 8'h00;
			rxa_q   <= 1'b1;
			pc_q    <= 16'd0;
		end else if (q_pop) begin
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			cmd_q   <= cmd_n;
			step_q  <= step_n;
			sub_q   <= sub_n;
			shift_q <= shift_n;
			rxb_q   <= rxb_n;
			rxa_q   <= rxa_n;
			pc_q    <= pc_n;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q.scl_level <= scl_n;
			out_q.sda_level <= sda_n;
			out_q.busy_res  <= (cmd_n != CMD_IDLE);
			out_q.done_res  <= done_n;
			out_q.rx_byte   <= rxb_n;
			out_q.rx_ack    <= rxa_n;
			out_q.status    <= status_n;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.scl_level = out_q.scl_level;
	assign res.sda_level = out_q.sda_level;
	assign res.busy_res  = out_q.busy_res;
	assign res.done_res  = out_q.done_res;
	assign res.rx_byte   = out_q.rx_byte;
	assign res.rx_ack    = out_q.rx_ack;
	assign res.status    = out_q.status;

endmodule
`default_nettype wire

FILE: rtl/i2c_bitbang_master.sv
// Top level of the I2C bit-level master: front end, queue, sequencer, config.
//
// Usage: the cmd channel carries one beat per tick or command (action, tx_byte,
// ack_bit, sda_in). Each accepted beat produces exactly one beat on the res
// channel with the pin levels, busy, done, last received byte and ack, and a
// status bit that flags a command refused while a sequence runs.
// Tick beats advance the current command by one pin step every phase_ticks
// ticks; commands take effect only when the sequencer is idle.
// Each beat is written into the queue and its result is registered in the
// output stage. Throughput is one beat per clock while res is ready; the
// sequencer updates its state once for each beat popped.
// A two-entry queue separates the front end from the sequencer, so cmd stays
// ready while a result waits; when res stalls the queue fills and cmd.ready
// drops after at most two more beats, with nothing lost.
// The cfg channel writes phase_ticks and is always ready; write it only when
// the block is idle.
// Reset releases both pins, clears the sequencer and sets phase_ticks to 20.
`default_nettype none
module i2c_bitbang_master import ibm_pkg::*; #(
	parameter int PRESCALE_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ibm_cmd_if.sink   cmd,
	ibm_res_if.source res,
	ibm_cfg_if.sink   cfg
);

	logic        q_full, q_push, q_pop, q_not_empty;
	item_t       push_item, pop_item;
	logic [15:0] phase_ticks_q;

	// Step length register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_RESET;
		end else if (cfg.valid) begin
			phase_ticks_q <= cfg.data;
		end
	end

	ibm_front u_front (
		.cmd    (cmd),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (push_item)
	);

	ibm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (pop_item)
	);

	ibm_back #(
		.PRESCALE_BITS (PRESCALE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_ticks (phase_ticks_q),
		.q_not_empty (q_not_empty),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.res         (res)
	);

endmodule
`default_nettype wire
